### rtl/bpc_pkg.sv
package bpc_pkg;

    // Default fixed-point formats
    localparam int SCALED_FRACTION_BITS = 24;
    localparam int RESULT_FRACTION_BITS = 8;

    // Extra reciprocal bits, removed again after the raw-sample multiply
    localparam int RECIP_EXTRA_BITS = 24;

    // Field widths
    localparam int SAMPLE_W   = 24;
    localparam int PRESSURE_W = 40;
    localparam int TEMP_W     = 24;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 40;

    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_LINEAR = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_LINEAR   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CROSS_LINEAR  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_SQUARE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CROSS_SQUARE  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_CUBE    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_PAIR     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_OSR_CODES     = 3'd7;

    // Oversampling scale factors, indexed by the 3-bit rate code
    localparam logic [63:0] SCALE_K [8] = '{
        64'd524288,  64'd1572864, 64'd3670016, 64'd7864320,
        64'd253952,  64'd516096,  64'd1040384, 64'd2088960
    };

endpackage

### rtl/bpc_mul.sv
// Two-stage signed multiply with a rounding right shift (half away from zero).
// Operand A is split in two halves; the partial products are registered,
// then summed together with the rounding constant. SHIFT must be at least 1.
module bpc_mul #(
    parameter int AW    = 32,
    parameter int BW    = 32,
    parameter int SHIFT = 24,
    parameter int OW    = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [OW-1:0] o_q
);

    localparam int LW = AW / 2;
    localparam int HW = AW - LW;
    localparam int PW = AW + BW;
    localparam logic [PW-1:0] RND = PW'(1) << (SHIFT - 1);

    logic signed [LW:0]         a_lo;
    logic signed [HW-1:0]       a_hi;
    logic signed [LW+BW:0]      r_lo;
    logic signed [HW+BW-1:0]    r_hi;
    logic                       r_neg;
    logic signed [PW-1:0]       r_sum;
    logic signed [PW-1:0]       n_sum;

    // Low half taken as unsigned, high half carries the sign
    assign a_lo = {1'b0, i_a[LW-1:0]};
    assign a_hi = i_a[AW-1:LW];

    // Recombine; negative products round with one less
    assign n_sum = signed'({r_hi, {LW{1'b0}}}) + PW'(r_lo)
                 + signed'(r_neg ? RND - PW'(1) : RND);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo  <= a_lo * i_b;
            r_hi  <= a_hi * i_b;
            r_neg <= i_a[AW-1] ^ i_b[BW-1];
            r_sum <= n_sum;
        end
    end

    assign o_q = OW'(r_sum >>> SHIFT);

endmodule

### rtl/baro_pressure_temp_compensation_top.sv
// Throughput: one transaction per cycle while the skid entry is empty; the
// depth comes from the chain of three dependent two-stage multipliers
// (scaling, then two Horner steps), followed by the output register.
// An output register plus one skid entry hold results while i_out_ready is low.
// Reset (synchronous, active low) empties the pipeline and clears every
// coefficient and rate code to zero.
module baro_pressure_temp_compensation_top #(
    parameter int SCALED_FRACTION_BITS = bpc_pkg::SCALED_FRACTION_BITS,
    parameter int RESULT_FRACTION_BITS = bpc_pkg::RESULT_FRACTION_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [bpc_pkg::SAMPLE_W-1:0]   i_pressure_sample,
    input  logic signed [bpc_pkg::SAMPLE_W-1:0]   i_temperature_sample,
    // Output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [bpc_pkg::PRESSURE_W-1:0] o_pressure_pascal,
    output logic signed [bpc_pkg::TEMP_W-1:0]     o_temperature_celsius,
    // Configuration writes
    input  logic                                  i_cfg_we,
    input  logic [bpc_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int F   = SCALED_FRACTION_BITS;
    localparam int RW  = F + 7;     // reciprocal, unsigned
    localparam int PW  = F + 7;     // scaled pressure / temperature
    localparam int AW  = F + 23;    // first Horner operand
    localparam int QW  = F + 27;    // first Horner product
    localparam int BW2 = F + 28;    // second Horner operand
    localparam int XW3 = F + 32;    // second Horner product
    localparam int XW  = F + 33;    // pressure sum
    localparam int TW  = F + 20;    // temperature sum
    localparam int S2  = SCALED_FRACTION_BITS - RESULT_FRACTION_BITS;
    localparam int PO  = bpc_pkg::PRESSURE_W;
    localparam int TO  = bpc_pkg::TEMP_W;

    // Reciprocal table: round(2^(F+extra) / k)
    localparam logic [63:0] RECIP_NUM =
        64'd1 << (SCALED_FRACTION_BITS + bpc_pkg::RECIP_EXTRA_BITS);
    localparam logic [RW-1:0] RECIP [8] = '{
        RW'((RECIP_NUM + bpc_pkg::SCALE_K[0] / 2) / bpc_pkg::SCALE_K[0]),
        RW'((RECIP_NUM + bpc_pkg::SCALE_K[1] / 2) / bpc_pkg::SCALE_K[1]),
        RW'((RECIP_NUM + bpc_pkg::SCALE_K[2] / 2) / bpc_pkg::SCALE_K[2]),
        RW'((RECIP_NUM + bpc_pkg::SCALE_K[3] / 2) / bpc_pkg::SCALE_K[3]),
        RW'((RECIP_NUM + bpc_pkg::SCALE_K[4] / 2) / bpc_pkg::SCALE_K[4]),
        RW'((RECIP_NUM + bpc_pkg::SCALE_K[5] / 2) / bpc_pkg::SCALE_K[5]),
        RW'((RECIP_NUM + bpc_pkg::SCALE_K[6] / 2) / bpc_pkg::SCALE_K[6]),
        RW'((RECIP_NUM + bpc_pkg::SCALE_K[7] / 2) / bpc_pkg::SCALE_K[7])
    };

    // Configuration registers
    logic signed [19:0] r_c00, r_c10;
    logic signed [15:0] r_c01, r_c11, r_c20, r_c21, r_c30;
    logic signed [11:0] r_c0, r_c1;
    logic [2:0]         r_pcode, r_tcode;

    // Pipeline control
    logic               en;
    logic               in_acc;
    logic [10:1]        r_vld;
    logic               r_o_vld;
    logic               r_sk_vld;

    // Datapath
    logic signed [RW:0]      recip_p, recip_t;
    logic signed [PW-1:0]    p_s, t_s;
    logic signed [PW-1:0]    r_p_d [3:7];
    logic signed [PW-1:0]    r_t_d [3:7];
    logic signed [AW-1:0]    r_x1, r_y1, r_a, r_yb;
    logic signed [TW-1:0]    r_tm;
    logic signed [TW-1:0]    r_ts_d [4:10];
    logic signed [QW-1:0]    x2, y2;
    logic signed [BW2-1:0]   r_b, r_yc;
    logic signed [XW3-1:0]   x3, y3;
    logic signed [XW-1:0]    r_s;
    logic signed [XW-1:0]    p_rnd;
    logic signed [TW-1:0]    t_rnd;
    logic signed [PO-1:0]    n_pres, r_o_pres, r_sk_pres;
    logic signed [TO-1:0]    n_temp, r_o_temp, r_sk_temp;

    // Configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c00   <= '0;
            r_c10   <= '0;
            r_c01   <= '0;
            r_c11   <= '0;
            r_c20   <= '0;
            r_c21   <= '0;
            r_c30   <= '0;
            r_c0    <= '0;
            r_c1    <= '0;
            r_pcode <= '0;
            r_tcode <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bpc_pkg::CFG_OFFSET_LINEAR: begin
                    r_c00 <= i_cfg_data[39:20];
                    r_c10 <= i_cfg_data[19:0];
                end
                bpc_pkg::CFG_TEMP_LINEAR:  r_c01 <= i_cfg_data[15:0];
                bpc_pkg::CFG_CROSS_LINEAR: r_c11 <= i_cfg_data[15:0];
                bpc_pkg::CFG_PRESS_SQUARE: r_c20 <= i_cfg_data[15:0];
                bpc_pkg::CFG_CROSS_SQUARE: r_c21 <= i_cfg_data[15:0];
                bpc_pkg::CFG_PRESS_CUBE:   r_c30 <= i_cfg_data[15:0];
                bpc_pkg::CFG_TEMP_PAIR: begin
                    r_c0 <= i_cfg_data[23:12];
                    r_c1 <= i_cfg_data[11:0];
                end
                bpc_pkg::CFG_OSR_CODES: begin
                    r_pcode <= i_cfg_data[2:0];
                    r_tcode <= i_cfg_data[5:3];
                end
                default: ;
            endcase
        end
    end

    // Whole pipeline advances unless the skid entry is occupied
    assign en         = !r_sk_vld;
    assign in_acc     = i_in_valid && en;
    assign o_in_ready = en;

    // Stages 1-2: scale raw samples by the reciprocal of the rate factor
    assign recip_p = {1'b0, RECIP[r_pcode]};
    assign recip_t = {1'b0, RECIP[r_tcode]};

    bpc_mul #(
        .AW(RW + 1), .BW(bpc_pkg::SAMPLE_W),
        .SHIFT(bpc_pkg::RECIP_EXTRA_BITS), .OW(PW)
    ) u_scale_p (
        .i_clk(i_clk), .i_en(en), .i_a(recip_p), .i_b(i_pressure_sample), .o_q(p_s)
    );

    bpc_mul #(
        .AW(RW + 1), .BW(bpc_pkg::SAMPLE_W),
        .SHIFT(bpc_pkg::RECIP_EXTRA_BITS), .OW(PW)
    ) u_scale_t (
        .i_clk(i_clk), .i_en(en), .i_a(recip_t), .i_b(i_temperature_sample), .o_q(t_s)
    );

    // Stages 3-4: inner coefficient products and offsets
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x1    <= AW'(r_c30) * AW'(p_s);
            r_y1    <= AW'(r_c21) * AW'(p_s);
            r_tm    <= TW'(r_c1) * TW'(t_s);
            r_a     <= (AW'(r_c20) <<< F) + r_x1;
            r_yb    <= (AW'(r_c11) <<< F) + r_y1;
            r_ts_d[4] <= (TW'(r_c0) <<< (F - 1)) + r_tm;
            r_p_d[3] <= p_s;
            r_t_d[3] <= t_s;
            for (int k = 4; k <= 7; k++) begin
                r_p_d[k] <= r_p_d[k-1];
                r_t_d[k] <= r_t_d[k-1];
            end
            for (int k = 5; k <= 10; k++) begin
                r_ts_d[k] <= r_ts_d[k-1];
            end
        end
    end

    // Stages 5-6: first Horner step in p for both branches
    bpc_mul #(.AW(AW), .BW(PW), .SHIFT(F), .OW(QW)) u_mul_ap (
        .i_clk(i_clk), .i_en(en), .i_a(r_a), .i_b(r_p_d[4]), .o_q(x2)
    );

    bpc_mul #(.AW(AW), .BW(PW), .SHIFT(F), .OW(QW)) u_mul_yp (
        .i_clk(i_clk), .i_en(en), .i_a(r_yb), .i_b(r_p_d[4]), .o_q(y2)
    );

    // Stage 7: add linear coefficients
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b  <= BW2'(x2) + (BW2'(r_c10) <<< F);
            r_yc <= BW2'(y2) + (BW2'(r_c01) <<< F);
        end
    end

    // Stages 8-9: outer multiply, by p for pressure and by t for cross terms
    bpc_mul #(.AW(BW2), .BW(PW), .SHIFT(F), .OW(XW3)) u_mul_bp (
        .i_clk(i_clk), .i_en(en), .i_a(r_b), .i_b(r_p_d[7]), .o_q(x3)
    );

    bpc_mul #(.AW(BW2), .BW(PW), .SHIFT(F), .OW(XW3)) u_mul_yt (
        .i_clk(i_clk), .i_en(en), .i_a(r_yc), .i_b(r_t_d[7]), .o_q(y3)
    );

    // Stage 10: pressure sum with offset
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s <= XW'(x3) + XW'(y3) + (XW'(r_c00) <<< F);
        end
    end

    // Round to the result format, half away from zero
    generate
        if (S2 == 0) begin : g_no_round
            assign p_rnd = r_s;
            assign t_rnd = r_ts_d[10];
        end else begin : g_round
            localparam int RND2 = 1 << (S2 - 1);
            assign p_rnd = signed'(r_s + signed'(r_s[XW-1] ? XW'(RND2 - 1) : XW'(RND2)))
                           >>> S2;
            assign t_rnd = signed'(r_ts_d[10]
                           + signed'(r_ts_d[10][TW-1] ? TW'(RND2 - 1) : TW'(RND2)))
                           >>> S2;
        end
    endgenerate

    // Saturate when the upper bits are not all sign copies
    always_comb begin
        if ((&p_rnd[XW-1:PO-1]) || !(|p_rnd[XW-1:PO-1])) begin
            n_pres = p_rnd[PO-1:0];
        end else begin
            n_pres = p_rnd[XW-1] ? {1'b1, {(PO-1){1'b0}}} : {1'b0, {(PO-1){1'b1}}};
        end
        if ((&t_rnd[TW-1:TO-1]) || !(|t_rnd[TW-1:TO-1])) begin
            n_temp = t_rnd[TO-1:0];
        end else begin
            n_temp = t_rnd[TW-1] ? {1'b1, {(TO-1){1'b0}}} : {1'b0, {(TO-1){1'b1}}};
        end
    end

    // Valid bits, output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_o_vld  <= 1'b0;
            r_sk_vld <= 1'b0;
        end else if (en) begin
            r_vld <= {r_vld[9:1], in_acc};
            if (!r_o_vld || i_out_ready) begin
                r_o_vld <= r_vld[10];
            end else if (r_vld[10]) begin
                r_sk_vld <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_sk_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (!r_o_vld || i_out_ready) begin
                r_o_pres <= n_pres;
                r_o_temp <= n_temp;
            end else begin
                r_sk_pres <= n_pres;
                r_sk_temp <= n_temp;
            end
        end else if (i_out_ready) begin
            r_o_pres <= r_sk_pres;
            r_o_temp <= r_sk_temp;
        end
    end

    assign o_out_valid           = r_o_vld;
    assign o_pressure_pascal     = r_o_pres;
    assign o_temperature_celsius = r_o_temp;

`ifndef NO_ASSERTIONS
    // Skid entry only fills behind a stalled, valid output
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_vld) |-> $past(r_o_vld && !i_out_ready))
        else $error("skid filled without output stall");

    // An occupied skid entry always has a result in front of it
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_vld |-> r_o_vld)
        else $error("skid holds a transaction while output register is empty");

    // A frozen pipeline keeps its valid bits
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(en)) |-> $stable(r_vld))
        else $error("pipeline valid bits moved during stall");

    // A finished transaction reaches a free output register
    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[10] && (!r_o_vld || i_out_ready)) |=> r_o_vld)
        else $error("finished transaction lost at output");
`endif

endmodule
